// ===== sv/rwlu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rwlu_pkg;

    // Request codes carried in tuser
    typedef enum logic [2:0] {
        OP_READ          = 3'd0,
        OP_RESERVED_READ = 3'd1,
        OP_REQ_RESERVE   = 3'd2,
        OP_REL_RESERVE   = 3'd3,
        OP_READ_UNLOCK   = 3'd4,
        OP_WRITE_TRY     = 3'd5,
        OP_WRITE_ABANDON = 3'd6,
        OP_WRITE_UNLOCK  = 3'd7
    } t_op;

    localparam int ID_W    = 8;
    localparam int PRIO_W  = 5;
    localparam int COUNT_W = 8;
    localparam int PEND_W  = 6;

    // Pending writer priority when no writer is waiting
    localparam logic signed [PEND_W-1:0] NO_REQUEST = -6'sd1;

    typedef struct packed {
        logic               wake_writers;
        logic               wake_readers;
        logic [ID_W-1:0]    reservation_holder;
        logic               reservation_taken;
        logic               writer_holds;
        logic [COUNT_W-1:0] readers_now;
        logic               ok;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/reader_writer_lock_upgradable.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  tdata (low bit up)                                tuser
// s_axis   in   requester_id[7:0], requester_priority[12:8], pad  req_type[2:0]
// m_axis   out  ok[0], readers_now[8:1], writer_holds[9],         -
//               reservation_taken[10], reservation_holder[18:11],
//               wake_readers[19], wake_writers[20], pad
//
// One request per cycle; its result appears in the output register on the
// cycle after acceptance. The lock state updates at the acceptance edge, so
// a following request sees it immediately.
// i_rst_n (synchronous, active low) clears the lock state and the output valid.
// A stalled result holds; a new request is taken only as the result leaves.
module reader_writer_lock_upgradable #(
    parameter int MAX_READERS = 255,
    parameter int ID_BITS     = 8,
    parameter int PRIO_LEVELS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // requester_id, requester_priority
    input  wire logic [2:0]  s_axis_tuser,   // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // ok .. wake_writers, see table
);

    localparam int ID_W    = rwlu_pkg::ID_W;
    localparam int PRIO_W  = rwlu_pkg::PRIO_W;
    localparam int COUNT_W = rwlu_pkg::COUNT_W;
    localparam int PEND_W  = rwlu_pkg::PEND_W;

    localparam logic [ID_W-1:0] ID_MASK =
        (ID_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((1 << ID_BITS) - 1);
    localparam logic [COUNT_W-1:0] COUNT_CAP =
        (MAX_READERS < 255) ? COUNT_W'(MAX_READERS) : COUNT_W'(255);
    localparam logic [PRIO_W-1:0] PRIO_MAX =
        (PRIO_LEVELS - 1 < 31) ? PRIO_W'(PRIO_LEVELS - 1) : PRIO_W'(31);

    logic [COUNT_W-1:0]             r_count, n_count;
    logic                           r_write_held, n_write_held;
    logic                           r_res_valid, n_res_valid;
    logic [ID_W-1:0]                r_res_owner, n_res_owner;
    logic signed [PEND_W-1:0]       r_pend, n_pend;
    logic                           r_out_valid;
    rwlu_pkg::t_result              r_result, n_result;

    rwlu_pkg::t_op                  op;
    logic [ID_W-1:0]                id;
    logic [PRIO_W-1:0]              prio_in, prio;
    logic signed [PEND_W-1:0]       prio_s;
    logic                           owns, ok, wake_rd, wake_wr, accept;
    logic                           read_open;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_result};

    assign op      = rwlu_pkg::t_op'(s_axis_tuser);
    assign id      = s_axis_tdata[ID_W-1:0] & ID_MASK;
    assign prio_in = s_axis_tdata[ID_W +: PRIO_W];
    assign prio    = (prio_in > PRIO_MAX) ? PRIO_MAX : prio_in;
    assign prio_s  = $signed({1'b0, prio});
    assign owns    = r_res_valid && (r_res_owner == id);
    assign read_open = !r_write_held && (prio_s > r_pend) && (r_count < COUNT_CAP);

    always_comb begin
        n_count      = r_count;
        n_write_held = r_write_held;
        n_res_valid  = r_res_valid;
        n_res_owner  = r_res_owner;
        n_pend       = r_pend;
        ok           = 1'b0;
        wake_rd      = 1'b0;
        wake_wr      = 1'b0;
        case (op)
            rwlu_pkg::OP_READ: begin
                if (read_open) begin
                    n_count = r_count + 1'b1;
                    ok      = 1'b1;
                end
            end
            rwlu_pkg::OP_RESERVED_READ: begin
                if (read_open && !r_res_valid) begin
                    n_count     = r_count + 1'b1;
                    n_res_valid = 1'b1;
                    n_res_owner = id;
                    ok          = 1'b1;
                end
            end
            rwlu_pkg::OP_REQ_RESERVE: begin
                if (!r_write_held && (r_count != '0) && !r_res_valid) begin
                    n_res_valid = 1'b1;
                    n_res_owner = id;
                    ok          = 1'b1;
                end
            end
            rwlu_pkg::OP_REL_RESERVE: begin
                if (owns) begin
                    n_res_valid = 1'b0;
                    n_res_owner = '0;
                    wake_rd     = 1'b1;
                    ok          = 1'b1;
                end
            end
            rwlu_pkg::OP_READ_UNLOCK: begin
                if (owns) begin
                    n_res_valid = 1'b0;
                    n_res_owner = '0;
                    wake_rd     = 1'b1;
                end
                if (!r_write_held) begin
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                        ok      = 1'b1;
                    end
                    // last reader gone: reservation goes with it
                    if (r_count <= COUNT_W'(1)) begin
                        n_res_valid = 1'b0;
                        n_res_owner = '0;
                        wake_wr     = 1'b1;
                    end
                end
            end
            rwlu_pkg::OP_WRITE_TRY: begin
                if (!r_write_held && (r_count <= {{(COUNT_W-1){1'b0}}, owns})) begin
                    n_write_held = 1'b1;
                    n_count      = '0;
                    n_pend       = rwlu_pkg::NO_REQUEST;
                    ok           = 1'b1;
                end else if (r_pend < prio_s) begin
                    n_pend = prio_s;
                end
            end
            rwlu_pkg::OP_WRITE_ABANDON: begin
                if (r_pend == prio_s) begin
                    n_pend  = rwlu_pkg::NO_REQUEST;
                    wake_rd = 1'b1;
                    wake_wr = 1'b1;
                    ok      = 1'b1;
                end
            end
            rwlu_pkg::OP_WRITE_UNLOCK: begin
                if (r_write_held) begin
                    n_write_held = 1'b0;
                    // reservation holder drops back to a single reader
                    n_count      = {{(COUNT_W-1){1'b0}}, owns};
                    wake_rd      = 1'b1;
                    wake_wr      = 1'b1;
                    ok           = 1'b1;
                end
            end
            default: begin
            end
        endcase

        n_result.ok                 = ok;
        n_result.readers_now        = n_count;
        n_result.writer_holds       = n_write_held;
        n_result.reservation_taken  = n_res_valid;
        n_result.reservation_holder = n_res_valid ? n_res_owner : '0;
        n_result.wake_readers       = wake_rd;
        n_result.wake_writers       = wake_wr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_write_held <= 1'b0;
            r_res_valid  <= 1'b0;
            r_res_owner  <= '0;
            r_pend       <= rwlu_pkg::NO_REQUEST;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_count      <= n_count;
                r_write_held <= n_write_held;
                r_res_valid  <= n_res_valid;
                r_res_owner  <= n_res_owner;
                r_pend       <= n_pend;
                r_out_valid  <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    a_writer_excludes_readers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_write_held |-> (r_count == '0))
        else $error("readers counted while writer holds");

    a_count_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_CAP)
        else $error("reader count above cap");

    a_owner_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_res_valid |-> (r_res_owner == '0))
        else $error("stale reservation owner");

    a_grant_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_write_held) |-> (r_pend == rwlu_pkg::NO_REQUEST))
        else $error("pending writer left after write grant");

    a_holder_only_when_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_result.reservation_taken) |-> (r_result.reservation_holder == '0))
        else $error("holder reported without reservation");

endmodule

`default_nettype wire
